FILE: design/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, codes and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // quotient bits resolved by the divider; anything at or above 2^Q_BITS is
    // flagged as too big before the first step
    localparam int Q_BITS        = 33;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [65:0] POS_LIM = 66'sd2147483647;
    localparam logic signed [65:0] NEG_LIM = -66'sd2147483648;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [1:0]         status;
    } t_out_word;

    // front end result: exact values (multiply already floored)
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [65:0] re;
        logic signed [65:0] im;
        logic [63:0]        den;
    } t_front;

    // one divider stage
    typedef struct packed {
        logic              div;
        logic              zero;
        logic              neg_re;
        logic              neg_im;
        logic              big_re;
        logic              big_im;
        logic [63:0]       den;
        logic [63:0]       rem_re;
        logic [63:0]       rem_im;
        logic [Q_BITS-1:0] nlo_re;
        logic [Q_BITS-1:0] nlo_im;
        logic [Q_BITS-1:0] q_re;
        logic [Q_BITS-1:0] q_im;
        t_out_word         pass;
    } t_dstage;

    // saturate to 32 bits; MSB of the result is the overflow flag
    function automatic logic [32:0] sat66(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > POS_LIM) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < NEG_LIM) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

FILE: design/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Input register, six 32x32 multipliers, then sums/differences and floor shift.
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cau_pkg::t_in_word i_data,
    output logic              o_valid,
    output cau_pkg::t_front   o_front
);
    import cau_pkg::*;

    t_in_word r_in;
    logic     r_v0, r_v1, r_v2;

    logic signed [63:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [32:0] r_as_re, r_as_im;
    logic [1:0]         r_cmd1;
    t_front             r_out;

    logic signed [63:0] n_p_rr, n_p_ii, n_p_ri, n_p_ir, n_sq_r, n_sq_i;
    logic signed [32:0] n_as_re, n_as_im;
    logic signed [65:0] d_re, d_im;
    t_front             n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // stage 1: products and add/subtract sums
    always_comb begin
        n_p_rr = $signed(r_in.a_real) * $signed(r_in.b_real);
        n_p_ii = $signed(r_in.a_imag) * $signed(r_in.b_imag);
        n_p_ri = $signed(r_in.a_real) * $signed(r_in.b_imag);
        n_p_ir = $signed(r_in.a_imag) * $signed(r_in.b_real);
        n_sq_r = $signed(r_in.b_real) * $signed(r_in.b_real);
        n_sq_i = $signed(r_in.b_imag) * $signed(r_in.b_imag);
        if (r_in.cmd == CMD_SUB) begin
            n_as_re = 33'($signed(r_in.a_real)) - 33'($signed(r_in.b_real));
            n_as_im = 33'($signed(r_in.a_imag)) - 33'($signed(r_in.b_imag));
        end else begin
            n_as_re = 33'($signed(r_in.a_real)) + 33'($signed(r_in.b_real));
            n_as_im = 33'($signed(r_in.a_imag)) + 33'($signed(r_in.b_imag));
        end
    end

    // stage 2: combine
    always_comb begin
        d_re      = '0;
        d_im      = '0;
        n_out.cmd = r_cmd1;
        n_out.den = 64'(r_sq_r) + 64'(r_sq_i);
        unique case (r_cmd1)
            CMD_ADD, CMD_SUB: begin
                d_re = 66'(r_as_re);
                d_im = 66'(r_as_im);
            end
            CMD_MUL: begin
                d_re = (66'(r_p_rr) - 66'(r_p_ii)) >>> FRAC_BITS;
                d_im = (66'(r_p_ri) + 66'(r_p_ir)) >>> FRAC_BITS;
            end
            default: begin
                d_re = 66'(r_p_rr) + 66'(r_p_ii);
                d_im = 66'(r_p_ir) - 66'(r_p_ri);
            end
        endcase
        n_out.re = d_re;
        n_out.im = d_im;
    end

    always_ff @(posedge i_clk) begin
        r_in    <= i_data;
        r_p_rr  <= n_p_rr;
        r_p_ii  <= n_p_ii;
        r_p_ri  <= n_p_ri;
        r_p_ir  <= n_p_ir;
        r_sq_r  <= n_sq_r;
        r_sq_i  <= n_sq_i;
        r_as_re <= n_as_re;
        r_as_im <= n_as_im;
        r_cmd1  <= r_in.cmd;
        r_out   <= n_out;
    end

    assign o_valid = r_v2;
    assign o_front = r_out;

endmodule

FILE: design/cau_div_step.sv
// ----------------------------------------------------------------------------
// cau_div_step
// One restoring-division step for both parts: one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_div_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cau_pkg::t_dstage i_st,
    output logic             o_valid,
    output cau_pkg::t_dstage o_st
);
    import cau_pkg::*;

    logic    r_valid;
    t_dstage r_st;
    t_dstage n_st;
    logic [64:0] t_re, t_im;

    always_comb begin
        n_st = i_st;
        t_re = {i_st.rem_re, i_st.nlo_re[Q_BITS-1]};
        t_im = {i_st.rem_im, i_st.nlo_im[Q_BITS-1]};
        n_st.nlo_re = {i_st.nlo_re[Q_BITS-2:0], 1'b0};
        n_st.nlo_im = {i_st.nlo_im[Q_BITS-2:0], 1'b0};
        if (t_re >= {1'b0, i_st.den}) begin
            n_st.rem_re = 64'(t_re - {1'b0, i_st.den});
            n_st.q_re   = {i_st.q_re[Q_BITS-2:0], 1'b1};
        end else begin
            n_st.rem_re = t_re[63:0];
            n_st.q_re   = {i_st.q_re[Q_BITS-2:0], 1'b0};
        end
        if (t_im >= {1'b0, i_st.den}) begin
            n_st.rem_im = 64'(t_im - {1'b0, i_st.den});
            n_st.q_im   = {i_st.q_im[Q_BITS-2:0], 1'b1};
        end else begin
            n_st.rem_im = t_im[63:0];
            n_st.q_im   = {i_st.q_im[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

FILE: design/cau_div.sv
// ----------------------------------------------------------------------------
// cau_div
// Divide setup (sign/magnitude, range check, saturation of other ops) and
// the chain of quotient-bit stages.
// ----------------------------------------------------------------------------
module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  cau_pkg::t_front  i_front,
    output logic             o_valid,
    output cau_pkg::t_dstage o_st
);
    import cau_pkg::*;

    localparam int NW = 64 + FRAC_BITS;

    logic    r_valid;
    t_dstage r_st;
    t_dstage n_st;

    logic signed [65:0]   abs_re, abs_im;
    logic [NW-1:0]        num_re, num_im;
    logic [NW-Q_BITS-1:0] hi_re, hi_im;
    logic [32:0]          s_re, s_im;

    always_comb begin
        abs_re = i_front.re[65] ? (66'sd0 - i_front.re) : i_front.re;
        abs_im = i_front.im[65] ? (66'sd0 - i_front.im) : i_front.im;
        num_re = {abs_re[63:0], {FRAC_BITS{1'b0}}};
        num_im = {abs_im[63:0], {FRAC_BITS{1'b0}}};
        hi_re  = num_re[NW-1:Q_BITS];
        hi_im  = num_im[NW-1:Q_BITS];
        s_re   = sat66(i_front.re);
        s_im   = sat66(i_front.im);

        n_st.div    = (i_front.cmd == CMD_DIV);
        n_st.zero   = (i_front.den == 64'd0);
        n_st.neg_re = i_front.re[65];
        n_st.neg_im = i_front.im[65];
        n_st.big_re = ({{Q_BITS{1'b0}}, hi_re} >= {{FRAC_BITS{1'b0}}, i_front.den});
        n_st.big_im = ({{Q_BITS{1'b0}}, hi_im} >= {{FRAC_BITS{1'b0}}, i_front.den});
        n_st.den    = i_front.den;
        n_st.rem_re = 64'(hi_re);
        n_st.rem_im = 64'(hi_im);
        n_st.nlo_re = num_re[Q_BITS-1:0];
        n_st.nlo_im = num_im[Q_BITS-1:0];
        n_st.q_re   = '0;
        n_st.q_im   = '0;
        n_st.pass.res_real = s_re[31:0];
        n_st.pass.res_imag = s_im[31:0];
        n_st.pass.status   = (s_re[32] || s_im[32]) ? ST_OVF : ST_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st <= n_st;
    end

    logic    v_chain  [Q_BITS+1];
    t_dstage st_chain [Q_BITS+1];

    assign v_chain[0]  = r_valid;
    assign st_chain[0] = r_st;

    for (genvar g = 0; g < Q_BITS; g++) begin : g_step
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_chain[g]),
            .i_st    (st_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_st    (st_chain[g+1])
        );
    end

    assign o_valid = v_chain[Q_BITS];
    assign o_st    = st_chain[Q_BITS];

endmodule

FILE: design/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add/subtract/multiply/divide on signed Q16.16 operands.
// ----------------------------------------------------------------------------
// A new word may be started in every clock cycle; busy is never raised. Each
// word produces exactly one result word, shown for one cycle with o_valid.
// The path has 38 register stages: input register, multiplier stage, combine
// stage, divider setup, 33 quotient-bit stages and the output register, and
// every operation code passes through all of them. The latency is set by the
// divider chain, which resolves one quotient bit per stage; add, subtract and
// multiply ride alongside it so results leave in the order words came in. The
// receiver cannot stall, so the pipeline has no back pressure.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  cau_pkg::t_in_word  i_data,
    output logic               o_valid,
    output cau_pkg::t_out_word o_result
);
    import cau_pkg::*;

    logic    fr_valid;
    t_front  fr_data;
    logic    dv_valid;
    t_dstage dv_st;

    logic      r_valid;
    t_out_word r_out;
    t_out_word n_out;

    logic signed [65:0] v_re, v_im;
    logic [32:0]        s_re, s_im;

    // no back pressure anywhere: a word is taken on every start
    assign busy = 1'b0;

    cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_data  (i_data),
        .o_valid (fr_valid),
        .o_front (fr_data)
    );

    cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_front (fr_data),
        .o_valid (dv_valid),
        .o_st    (dv_st)
    );

    // final result: divide quotient gets its sign back and is saturated;
    // other ops were already saturated at divider setup
    always_comb begin
        v_re = dv_st.neg_re ? (66'sd0 - $signed(66'(dv_st.q_re)))
                            : $signed(66'(dv_st.q_re));
        v_im = dv_st.neg_im ? (66'sd0 - $signed(66'(dv_st.q_im)))
                            : $signed(66'(dv_st.q_im));
        s_re = dv_st.big_re ? {1'b1, (dv_st.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF)}
                            : sat66(v_re);
        s_im = dv_st.big_im ? {1'b1, (dv_st.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF)}
                            : sat66(v_im);
        if (!dv_st.div) begin
            n_out = dv_st.pass;
        end else if (dv_st.zero) begin
            n_out.res_real = '0;
            n_out.res_imag = '0;
            n_out.status   = ST_DIV0;
        end else begin
            n_out.res_real = s_re[31:0];
            n_out.res_imag = s_im[31:0];
            n_out.status   = (s_re[32] || s_im[32]) ? ST_OVF : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule
